// ----- design/vadt_pkg.sv -----
// Package: sizes, status codes and slot record for the vertex attribute dedup table.
`timescale 1ns / 1ps

package vadt_pkg;

    // Table geometry
    localparam int VERTS   = 4096;
    localparam int ATTACH  = 16;
    localparam int IDX_W   = 12;
    localparam int BUCKETS = 1 << IDX_W;
    localparam int SLOTS   = BUCKETS * ATTACH;
    localparam int ADDR_W  = $clog2(SLOTS);
    localparam int SLOT_W  = (ATTACH > 1) ? $clog2(ATTACH) : 1;
    localparam int CNT_W   = $clog2(ATTACH + 1);
    localparam int NEXT_W  = $clog2(VERTS + 1);

    // Split counter
    localparam int SPLIT_W = 13;
    localparam logic [SPLIT_W-1:0] SPLIT_MAX = {SPLIT_W{1'b1}};

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_EXHAUSTED = 2'd2;

    // Mode codes
    localparam logic MODE_LOOKUP = 1'b0;
    localparam logic MODE_CLEAR  = 1'b1;

    // One stored slot
    typedef struct packed {
        logic [IDX_W-1:0] tex;
        logic [IDX_W-1:0] nrm;
        logic [IDX_W-1:0] idx;
    } t_slot;

endpackage

// ----- design/vertex_attribute_dedup_table_top.sv -----
// Top level: bucketed triplet dedup table with a serial slot compare sequencer.
// Lookup: read the bucket fill count, compare the filled slots in order until a hit; a miss goes to a fill decision.
// A clear word starts a pass that writes every bucket fill count to zero.
// One word in work at a time: the next is taken in the cycle after a result loads.
// Reset (synchronous, active low) starts the same clearing pass; stall stays high.
// The result register lets the next word start while a result waits to be taken.
`timescale 1ns / 1ps

module vertex_attribute_dedup_table_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_mode,
    input  logic [vadt_pkg::IDX_W-1:0]          i_position_index,
    input  logic [vadt_pkg::IDX_W-1:0]          i_texcoord_index,
    input  logic [vadt_pkg::IDX_W-1:0]          i_normal_index,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [vadt_pkg::IDX_W-1:0]          o_out_index,
    output logic [vadt_pkg::IDX_W-1:0]          o_base_index,
    output logic                                o_newly_added,
    output logic                                o_split_link,
    output logic [vadt_pkg::SPLIT_W-1:0]        o_split_total,
    output logic [1:0]                          o_status
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CNT    = 3'd1;
    localparam logic [2:0] S_CMP    = 3'd2;
    localparam logic [2:0] S_DECIDE = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;
    localparam logic [2:0] S_CLR    = 3'd5;

    localparam logic [vadt_pkg::IDX_W-1:0] LAST_BUCKET = {vadt_pkg::IDX_W{1'b1}};

    // Memories: per-bucket fill count and slot records
    logic [vadt_pkg::CNT_W-1:0] cnt_mem [vadt_pkg::BUCKETS];
    vadt_pkg::t_slot            slot_mem [vadt_pkg::SLOTS];

    logic [2:0]                   r_state;
    logic                         r_clr_item;
    logic [vadt_pkg::IDX_W-1:0]   r_clr_addr;
    logic [vadt_pkg::IDX_W-1:0]   r_pos;
    logic [vadt_pkg::IDX_W-1:0]   r_tex;
    logic [vadt_pkg::IDX_W-1:0]   r_nrm;
    logic [vadt_pkg::CNT_W-1:0]   r_cnt;
    logic [vadt_pkg::CNT_W-1:0]   r_cnt_q;
    vadt_pkg::t_slot              r_slot_q;
    logic [vadt_pkg::SLOT_W-1:0]  r_x;
    logic [vadt_pkg::NEXT_W-1:0]  r_next;
    logic [vadt_pkg::SPLIT_W-1:0] r_split;

    // Pending result
    logic [vadt_pkg::IDX_W-1:0]   r_res_idx;
    logic [vadt_pkg::IDX_W-1:0]   r_res_base;
    logic                         r_res_added;
    logic                         r_res_link;
    logic [vadt_pkg::SPLIT_W-1:0] r_res_split;
    logic [1:0]                   r_res_status;

    // Output register
    logic                         r_out_valid;
    logic [vadt_pkg::IDX_W-1:0]   r_out_idx;
    logic [vadt_pkg::IDX_W-1:0]   r_out_base;
    logic                         r_out_added;
    logic                         r_out_link;
    logic [vadt_pkg::SPLIT_W-1:0] r_out_split;
    logic [1:0]                   r_out_status;

    logic                         accept;
    logic                         out_free;
    logic [vadt_pkg::IDX_W-1:0]   cnt_raddr;
    logic                         cnt_we;
    logic [vadt_pkg::IDX_W-1:0]   cnt_waddr;
    logic [vadt_pkg::CNT_W-1:0]   cnt_wdata;
    logic [vadt_pkg::SLOT_W-1:0]  x_rd;
    logic [vadt_pkg::ADDR_W-1:0]  slot_raddr;
    logic [vadt_pkg::ADDR_W-1:0]  slot_waddr;
    logic                         slot_we;
    vadt_pkg::t_slot              slot_wdata;
    logic                         hit;
    logic                         last_slot;
    logic                         full;
    logic                         exhausted;
    logic [vadt_pkg::IDX_W-1:0]   new_idx;

    assign accept   = i_valid && !o_stall;
    assign out_free = !r_out_valid || !i_stall;
    assign o_stall  = (r_state != S_IDLE);

    // Compare unit and fill decisions
    assign hit       = (r_slot_q.tex == r_tex) && (r_slot_q.nrm == r_nrm);
    assign last_slot = (vadt_pkg::CNT_W'(r_x) + vadt_pkg::CNT_W'(1)) == r_cnt;
    assign full      = (r_cnt == vadt_pkg::CNT_W'(vadt_pkg::ATTACH));
    assign exhausted = (r_next >= vadt_pkg::NEXT_W'(vadt_pkg::VERTS));
    assign new_idx   = vadt_pkg::IDX_W'(r_next);

    // Read addresses: bucket from the port at accept, slot scan one ahead
    assign cnt_raddr  = (r_state == S_IDLE) ? i_position_index : r_pos;
    assign x_rd       = (r_state == S_CMP) ? (r_x + vadt_pkg::SLOT_W'(1))
                                            : vadt_pkg::SLOT_W'(0);
    assign slot_raddr = vadt_pkg::ADDR_W'(r_pos) * vadt_pkg::ADDR_W'(vadt_pkg::ATTACH)
                        + vadt_pkg::ADDR_W'(x_rd);
    assign slot_waddr = vadt_pkg::ADDR_W'(r_pos) * vadt_pkg::ADDR_W'(vadt_pkg::ATTACH)
                        + vadt_pkg::ADDR_W'(r_cnt);

    // Write ports: clearing pass or a fill
    assign slot_we    = (r_state == S_DECIDE) && !full && !exhausted;
    assign slot_wdata = '{tex: r_tex, nrm: r_nrm, idx: new_idx};
    assign cnt_we     = (r_state == S_CLR) || slot_we;
    assign cnt_waddr  = (r_state == S_CLR) ? r_clr_addr : r_pos;
    assign cnt_wdata  = (r_state == S_CLR) ? '0 : (r_cnt + vadt_pkg::CNT_W'(1));

    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        r_cnt_q <= cnt_mem[cnt_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (slot_we) begin
            slot_mem[slot_waddr] <= slot_wdata;
        end
        r_slot_q <= slot_mem[slot_raddr];
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_clr_item <= 1'b0;
            r_clr_addr <= '0;
            r_next     <= '0;
            r_split    <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_pos <= i_position_index;
                        r_tex <= i_texcoord_index;
                        r_nrm <= i_normal_index;
                        if (i_mode == vadt_pkg::MODE_CLEAR) begin
                            r_state    <= S_CLR;
                            r_clr_item <= 1'b1;
                            r_clr_addr <= '0;
                            r_next     <= '0;
                            r_split    <= '0;
                        end else begin
                            r_state <= S_CNT;
                        end
                    end
                end
                S_CNT: begin
                    r_cnt        <= r_cnt_q;
                    r_x          <= '0;
                    r_res_base   <= '0;
                    r_res_idx    <= '0;
                    r_res_added  <= 1'b0;
                    r_res_link   <= 1'b0;
                    r_res_split  <= r_split;
                    r_res_status <= vadt_pkg::ST_OK;
                    r_state      <= (r_cnt_q == '0) ? S_DECIDE : S_CMP;
                end
                S_CMP: begin
                    if (r_x == '0) begin
                        r_res_base <= r_slot_q.idx;
                    end
                    if (hit) begin
                        r_res_idx <= r_slot_q.idx;
                        r_state   <= S_DONE;
                    end else if (last_slot) begin
                        r_state <= S_DECIDE;
                    end else begin
                        r_x <= r_x + vadt_pkg::SLOT_W'(1);
                    end
                end
                S_DECIDE: begin
                    r_state <= S_DONE;
                    if (full) begin
                        r_res_status <= vadt_pkg::ST_FULL;
                    end else if (exhausted) begin
                        r_res_status <= vadt_pkg::ST_EXHAUSTED;
                    end else begin
                        r_next      <= r_next + vadt_pkg::NEXT_W'(1);
                        r_res_idx   <= new_idx;
                        r_res_added <= 1'b1;
                        if (r_cnt == '0) begin
                            r_res_base <= new_idx;
                        end else begin
                            r_res_link <= 1'b1;
                            if (r_split != vadt_pkg::SPLIT_MAX) begin
                                r_split     <= r_split + vadt_pkg::SPLIT_W'(1);
                                r_res_split <= r_split + vadt_pkg::SPLIT_W'(1);
                            end
                        end
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                S_CLR: begin
                    r_clr_addr <= r_clr_addr + vadt_pkg::IDX_W'(1);
                    if (r_clr_addr == LAST_BUCKET) begin
                        r_clr_item <= 1'b0;
                        if (r_clr_item) begin
                            r_res_idx    <= '0;
                            r_res_base   <= '0;
                            r_res_added  <= 1'b0;
                            r_res_link   <= 1'b0;
                            r_res_split  <= '0;
                            r_res_status <= vadt_pkg::ST_OK;
                            r_state      <= S_DONE;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Output register: load a finished word, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_DONE) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && out_free) begin
            r_out_idx    <= r_res_idx;
            r_out_base   <= r_res_base;
            r_out_added  <= r_res_added;
            r_out_link   <= r_res_link;
            r_out_split  <= r_res_split;
            r_out_status <= r_res_status;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_out_index   = r_out_idx;
    assign o_base_index  = r_out_base;
    assign o_newly_added = r_out_added;
    assign o_split_link  = r_out_link;
    assign o_split_total = r_out_split;
    assign o_status      = r_out_status;

    // Checks
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != S_IDLE))
        else $error("accepted word did not start the sequencer");

    a_next_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next <= vadt_pkg::NEXT_W'(vadt_pkg::VERTS))
        else $error("output index counter passed its limit");

    a_fill_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECIDE) |-> (r_cnt <= vadt_pkg::CNT_W'(vadt_pkg::ATTACH)))
        else $error("bucket fill count beyond slot count");

    a_link_needs_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_split_link |-> o_newly_added && (o_status == vadt_pkg::ST_OK))
        else $error("split flagged without a fill");

    a_fill_bumps_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        slot_we |=> (r_next == $past(r_next) + vadt_pkg::NEXT_W'(1)))
        else $error("fill did not advance the output index counter");

endmodule

// ----- test/tb.sv -----
// Testbench for the vertex attribute dedup table: directed and random corner words checked against a predictor.
`timescale 1ns / 1ps

module tb;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 9;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_WORDS = 900;
    localparam int DRAIN_CYCLES = 40;
    localparam int RECENT_DEPTH = 64;
    localparam int TAIL_WORDS   = 80;
    localparam logic [vadt_pkg::IDX_W-1:0] MAX_IDX = {vadt_pkg::IDX_W{1'b1}};

    typedef struct {
        logic [vadt_pkg::IDX_W-1:0]   out_index;
        logic [vadt_pkg::IDX_W-1:0]   base_index;
        logic                         newly_added;
        logic                         split_link;
        logic [vadt_pkg::SPLIT_W-1:0] split_total;
        logic [1:0]                   status;
    } t_corner_result;

    typedef struct {
        logic [vadt_pkg::IDX_W-1:0] pos;
        logic [vadt_pkg::IDX_W-1:0] tex;
        logic [vadt_pkg::IDX_W-1:0] nrm;
    } t_corner;

    typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY} t_stall_pattern;
    typedef enum {PHASE_TIGHT, PHASE_WIDE, PHASE_CROWD} t_phase;

    // Track bucket contents and counters; slots fill in order, so a fill count per bucket suffices
    class t_scoreboard;
        int unsigned                  fill_count [vadt_pkg::BUCKETS];
        logic [vadt_pkg::IDX_W-1:0]   slot_tex [vadt_pkg::SLOTS];
        logic [vadt_pkg::IDX_W-1:0]   slot_nrm [vadt_pkg::SLOTS];
        logic [vadt_pkg::IDX_W-1:0]   slot_idx [vadt_pkg::SLOTS];
        int unsigned                  next_index;
        logic [vadt_pkg::SPLIT_W-1:0] split_count;
        t_corner_result               expected_q [$];
        int unsigned                  errors;

        function new();
            clear_table();
            errors = 0;
        endfunction

        function void clear_table();
            foreach (fill_count[b]) fill_count[b] = 0;
            next_index  = 0;
            split_count = '0;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        // Predict the result of one accepted word and update the table
        function void note_word(logic mode, logic [vadt_pkg::IDX_W-1:0] pos,
                                logic [vadt_pkg::IDX_W-1:0] tex,
                                logic [vadt_pkg::IDX_W-1:0] nrm);
            t_corner_result r;
            int unsigned    base;
            int unsigned    k;
            bit             hit;
            r   = '{default: '0};
            hit = 0;
            if (mode == vadt_pkg::MODE_CLEAR) begin
                clear_table();
            end else begin
                base     = pos * vadt_pkg::ATTACH;
                r.status = vadt_pkg::ST_OK;
                if (fill_count[pos] > 0)
                    r.base_index = slot_idx[base];
                // Scan filled slots for the same texcoord and normal
                for (k = 0; k < fill_count[pos] && !hit; k++) begin
                    if (slot_tex[base + k] == tex && slot_nrm[base + k] == nrm) begin
                        r.out_index = slot_idx[base + k];
                        hit = 1;
                    end
                end
                // Miss: full bucket wins over an exhausted index space
                if (!hit) begin
                    if (k == vadt_pkg::ATTACH) begin
                        r.status = vadt_pkg::ST_FULL;
                    end else if (next_index >= vadt_pkg::VERTS) begin
                        r.status = vadt_pkg::ST_EXHAUSTED;
                    end else begin
                        slot_tex[base + k] = tex;
                        slot_nrm[base + k] = nrm;
                        slot_idx[base + k] = next_index[vadt_pkg::IDX_W-1:0];
                        r.out_index        = next_index[vadt_pkg::IDX_W-1:0];
                        r.newly_added      = 1'b1;
                        next_index++;
                        fill_count[pos]++;
                        if (k == 0) begin
                            r.base_index = r.out_index;
                        end else begin
                            r.split_link = 1'b1;
                            if (split_count != vadt_pkg::SPLIT_MAX)
                                split_count++;
                        end
                    end
                end
                r.split_total = split_count;
            end
            expected_q.push_back(r);
        endfunction

        function void check_field(string name, logic [vadt_pkg::SPLIT_W-1:0] want,
                                  logic [vadt_pkg::SPLIT_W-1:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        // Compare one taken result with the oldest prediction
        function void check_result(t_corner_result got);
            t_corner_result want;
            if (expected_q.size() == 0) begin
                $error("result word with nothing expected: out_index %0d", got.out_index);
                errors++;
            end else begin
                want = expected_q.pop_front();
                check_field("out_index", want.out_index, got.out_index);
                check_field("base_index", want.base_index, got.base_index);
                check_field("newly_added", want.newly_added, got.newly_added);
                check_field("split_link", want.split_link, got.split_link);
                check_field("split_total", want.split_total, got.split_total);
                check_field("status", want.status, got.status);
            end
        endfunction
    endclass

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_valid;
    logic                         o_stall;
    logic                         i_mode;
    logic [vadt_pkg::IDX_W-1:0]   i_position_index;
    logic [vadt_pkg::IDX_W-1:0]   i_texcoord_index;
    logic [vadt_pkg::IDX_W-1:0]   i_normal_index;
    logic                         o_valid;
    logic                         i_stall;
    logic [vadt_pkg::IDX_W-1:0]   o_out_index;
    logic [vadt_pkg::IDX_W-1:0]   o_base_index;
    logic                         o_newly_added;
    logic                         o_split_link;
    logic [vadt_pkg::SPLIT_W-1:0] o_split_total;
    logic [1:0]                   o_status;

    t_scoreboard     sb;
    t_corner         recent_q [$];
    int              burst_left  = 0;
    int              stall_left  = 0;
    int              cycle_count = 0;
    t_stall_pattern  stall_kind  = STALL_NONE;

    vertex_attribute_dedup_table_top DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_mode           (i_mode),
        .i_position_index (i_position_index),
        .i_texcoord_index (i_texcoord_index),
        .i_normal_index   (i_normal_index),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_out_index      (o_out_index),
        .o_base_index     (o_base_index),
        .o_newly_added    (o_newly_added),
        .o_split_link     (o_split_link),
        .o_split_total    (o_split_total),
        .o_status         (o_status)
    );

    initial i_clk = 1'b0;
    always #CLK_HALF i_clk = ~i_clk;

    // Draw a random index across the whole field
    function automatic logic [vadt_pkg::IDX_W-1:0] rand_idx();
        return vadt_pkg::IDX_W'($urandom_range(0, MAX_IDX));
    endfunction

    // Send one word, idling between bursts; hold it until taken
    task automatic send_word(input logic mode, input logic [vadt_pkg::IDX_W-1:0] pos,
                             input logic [vadt_pkg::IDX_W-1:0] tex,
                             input logic [vadt_pkg::IDX_W-1:0] nrm);
        int      gap;
        t_corner c;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge i_clk);
                i_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        @(negedge i_clk);
        i_valid          <= 1'b1;
        i_mode           <= mode;
        i_position_index <= pos;
        i_texcoord_index <= tex;
        i_normal_index   <= nrm;
        @(posedge i_clk);
        while (o_stall !== 1'b0) @(posedge i_clk);
        sb.note_word(mode, pos, tex, nrm);
        if (mode == vadt_pkg::MODE_LOOKUP) begin
            c = '{pos, tex, nrm};
            recent_q.push_back(c);
            if (recent_q.size() > RECENT_DEPTH)
                void'(recent_q.pop_front());
        end
    endtask

    // Repeat a recently sent corner, or a fresh random one if none is held
    task automatic send_repeat();
        t_corner c;
        if (recent_q.size() == 0) begin
            send_word(vadt_pkg::MODE_LOOKUP, rand_idx(), rand_idx(), rand_idx());
        end else begin
            c = recent_q[$urandom_range(0, recent_q.size() - 1)];
            send_word(vadt_pkg::MODE_LOOKUP, c.pos, c.tex, c.nrm);
        end
    endtask

    task automatic send_clear();
        send_word(vadt_pkg::MODE_CLEAR, rand_idx(), rand_idx(), rand_idx());
    endtask

    // Receiver stalls in patterns: none, light, heavy
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_kind = t_stall_pattern'($urandom_range(0, 2));
            stall_left = $urandom_range(50, 300);
        end
        stall_left--;
        case (stall_kind)
            STALL_NONE: begin
                i_stall <= 1'b0;
            end
            STALL_LIGHT: begin
                i_stall <= ($urandom_range(0, 3) == 0);
            end
            default: begin
                i_stall <= ($urandom_range(0, 3) != 0);
            end
        endcase
    end

    // Take result words
    always @(posedge i_clk) begin
        t_corner_result got;
        if (i_rst_n && o_valid !== 1'b0 && i_stall == 1'b0) begin
            got.out_index   = o_out_index;
            got.base_index  = o_base_index;
            got.newly_added = o_newly_added;
            got.split_link  = o_split_link;
            got.split_total = o_split_total;
            got.status      = o_status;
            sb.check_result(got);
        end
    end

    // Watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        logic [vadt_pkg::IDX_W-1:0] pos_pool [3];
        logic [vadt_pkg::IDX_W-1:0] tex_pool [5];
        logic [vadt_pkg::IDX_W-1:0] nrm_pool [5];
        logic [vadt_pkg::IDX_W-1:0] full_pos;
        t_phase                     phase;
        int                         n;
        int                         random_words;

        i_rst_n          = 1'b0;
        i_valid          = 1'b0;
        i_mode           = vadt_pkg::MODE_LOOKUP;
        i_position_index = '0;
        i_texcoord_index = '0;
        i_normal_index   = '0;
        i_stall          = 1'b0;
        sb               = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty bucket, hits, splits, field extremes, full bucket, clear
        send_word(vadt_pkg::MODE_LOOKUP, '0, '0, '0);
        send_word(vadt_pkg::MODE_LOOKUP, '0, '0, '0);
        send_word(vadt_pkg::MODE_LOOKUP, '0, MAX_IDX, MAX_IDX);
        send_word(vadt_pkg::MODE_LOOKUP, MAX_IDX, MAX_IDX, '0);
        send_word(vadt_pkg::MODE_LOOKUP, MAX_IDX, '0, MAX_IDX);
        send_word(vadt_pkg::MODE_LOOKUP, MAX_IDX, MAX_IDX, '0);
        send_word(vadt_pkg::MODE_LOOKUP, MAX_IDX, '0, MAX_IDX);
        send_word(vadt_pkg::MODE_LOOKUP, '0, '0, MAX_IDX);
        for (int k = 0; k < vadt_pkg::ATTACH - 2; k++)
            send_word(vadt_pkg::MODE_LOOKUP, MAX_IDX, vadt_pkg::IDX_W'(k + 1),
                      vadt_pkg::IDX_W'(k + 1));
        send_word(vadt_pkg::MODE_LOOKUP, MAX_IDX, vadt_pkg::IDX_W'(100),
                  vadt_pkg::IDX_W'(200));
        send_word(vadt_pkg::MODE_LOOKUP, MAX_IDX, vadt_pkg::IDX_W'(vadt_pkg::ATTACH - 2),
                  vadt_pkg::IDX_W'(vadt_pkg::ATTACH - 2));
        send_clear();

        // Random phases: tight sets for hits and full buckets, wide spreads for fills, crowds to fill buckets
        random_words = 0;
        while (random_words < RANDOM_WORDS) begin
            phase = t_phase'($urandom_range(0, 2));
            n     = $urandom_range(40, 150);
            foreach (pos_pool[i]) pos_pool[i] = ($urandom_range(0, 7) == 0) ?
                                                MAX_IDX : rand_idx();
            foreach (tex_pool[i]) tex_pool[i] = rand_idx();
            foreach (nrm_pool[i]) nrm_pool[i] = rand_idx();
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(0, 19) == 0) begin
                    send_word(vadt_pkg::MODE_LOOKUP, rand_idx(), rand_idx(), rand_idx());
                end else if (phase == PHASE_TIGHT) begin
                    send_word(vadt_pkg::MODE_LOOKUP, pos_pool[$urandom_range(0, 2)],
                              tex_pool[$urandom_range(0, 4)], nrm_pool[$urandom_range(0, 4)]);
                end else if (phase == PHASE_WIDE && $urandom_range(0, 3) != 0) begin
                    send_word(vadt_pkg::MODE_LOOKUP, rand_idx(), rand_idx(), rand_idx());
                end else if (phase == PHASE_CROWD && $urandom_range(0, 9) < 7) begin
                    send_word(vadt_pkg::MODE_LOOKUP, pos_pool[$urandom_range(0, 2)],
                              rand_idx(), rand_idx());
                end else begin
                    send_repeat();
                end
            end
            random_words += n;
            if ($urandom_range(0, 3) == 0) begin
                send_clear();
                random_words++;
            end
        end

        // Fill one bucket to the brim, then mix full-bucket misses with other words
        send_clear();
        full_pos = rand_idx();
        for (int k = 0; k < vadt_pkg::ATTACH; k++)
            send_word(vadt_pkg::MODE_LOOKUP, full_pos, vadt_pkg::IDX_W'(k), rand_idx());
        for (int i = 0; i < TAIL_WORDS; i++) begin
            case ($urandom_range(0, 2))
                0: send_repeat();
                1: send_word(vadt_pkg::MODE_LOOKUP, full_pos,
                             vadt_pkg::IDX_W'($urandom_range(vadt_pkg::ATTACH, MAX_IDX)),
                             rand_idx());
                default: send_word(vadt_pkg::MODE_LOOKUP, rand_idx(), rand_idx(),
                                   rand_idx());
            endcase
        end

        // Drop valid, drain outstanding results, then settle
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
